// ===== src/lcdwe_pkg.sv =====
// Types and constants shared by the character LCD 4-bit write engine.
// No dependencies.
package lcdwe_pkg;

  // request kinds
  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_CHAR   = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_CURSOR = 3'd3;
  localparam logic [2:0] KIND_NUMBER = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BYTE_WAIT  = 2'd0;
  localparam logic [1:0] CFG_CLEAR_WAIT = 2'd1;
  localparam logic [1:0] CFG_CLEAR_CODE = 2'd2;

  localparam logic [15:0] BYTE_WAIT_RST  = 16'd40;
  localparam logic [15:0] CLEAR_WAIT_RST = 16'd5000;
  localparam logic [7:0]  CLEAR_CODE_RST = 8'd1;

  localparam logic [7:0] DDRAM_SET    = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;   // '0' is 0x30

  localparam int NUMBER_W   = 64;
  localparam int NUM_DIGITS = 20;                 // decimal digits of a 64-bit value
  localparam int DIGITS_W   = 4 * NUM_DIGITS;
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int CONV_CNT_W = $clog2(NUMBER_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_HI,
    ST_LO
  } state_t;

endpackage

// ===== src/lcdwe_if.sv =====
// Request and strobe channel interfaces of the LCD write engine.
// Depends on nothing; field widths follow the request and strobe formats.
interface lcdwe_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic [1:0]  row;
  logic [4:0]  column;
  logic [63:0] number;

  modport source(output valid, kind, byte_value, row, column, number, input ready);
  modport sink(input valid, kind, byte_value, row, column, number, output ready);
endinterface

interface lcdwe_strobe_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_us;
  logic        last;

  modport source(output valid, reg_select, nibble, wait_us, last, input ready);
  modport sink(input valid, reg_select, nibble, wait_us, last, output ready);
endinterface

// ===== src/lcdwe_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on lcdwe_pkg.
module lcdwe_dabble (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lcdwe_pkg::NUMBER_W-1:0]    value,
  output logic                              done,
  output logic [lcdwe_pkg::DIGITS_W-1:0]    bcd
);

  logic [lcdwe_pkg::NUMBER_W-1:0]   bin;
  logic [lcdwe_pkg::CONV_CNT_W-1:0] cnt;
  logic [lcdwe_pkg::DIGITS_W-1:0]   bcd_adj;

  // digits >= 5 get 3 added before the shift
  always_comb begin
    for (int i = 0; i < lcdwe_pkg::NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= lcdwe_pkg::CONV_CNT_W'(lcdwe_pkg::NUMBER_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == lcdwe_pkg::CONV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (cnt != '0) begin
      bin <= {bin[lcdwe_pkg::NUMBER_W-2:0], 1'b0};
      bcd <= {bcd_adj[lcdwe_pkg::DIGITS_W-2:0], bin[lcdwe_pkg::NUMBER_W-1]};
    end
  end

endmodule

// ===== src/char_lcd_4bit_write_engine_core.sv =====
// Top level of the character LCD 4-bit write engine.
// Depends on lcdwe_pkg, lcdwe_if and lcdwe_dabble.
// Usage:
//   req    : one request per handshake (command, character, clear, cursor
//            move or unsigned number). Taken only while the engine is idle.
//   strobe : one item per nibble enable pulse, high nibble first. The low
//            nibble carries the hold-off time and, on the final byte, last.
//   cfg_*  : register writes (byte wait, clear wait, clear code), to be applied
//            while idle (not enforced by the engine); index 3 is ignored.
// Sequence (no back-pressure):
//   command/char/clear/cursor: 2 strobes, high nibble from ST_HI then low
//     nibble from ST_LO, one strobe per cycle.
//   number: bit-serial BCD conversion, leading-zero skip, then one strobe
//     per cycle, high and low nibble of each digit in turn.
// The strobe side has its own output register, so the next request is taken
//   as soon as the final strobe is loaded, even if it is still waiting.
// A stalled receiver just holds the current strobe; nothing is dropped.
// Reset clears the state machine, empties the output register and restores
//   the registers to 40 us, 5000 us and code 0x01.
module char_lcd_4bit_write_engine_core #(
  parameter int MAX_DIGITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  lcdwe_req_if.sink            req,
  lcdwe_strobe_if.source       strobe,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int DW = lcdwe_pkg::DIGITS_W;
  localparam int RW = lcdwe_pkg::REM_W;

  // config registers
  logic [15:0] byte_wait_us;
  logic [15:0] clear_wait_us;
  logic [7:0]  clear_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_wait_us  <= lcdwe_pkg::BYTE_WAIT_RST;
      clear_wait_us <= lcdwe_pkg::CLEAR_WAIT_RST;
      clear_code    <= lcdwe_pkg::CLEAR_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdwe_pkg::CFG_BYTE_WAIT:  byte_wait_us  <= cfg_data;
        lcdwe_pkg::CFG_CLEAR_WAIT: clear_wait_us <= cfg_data;
        lcdwe_pkg::CFG_CLEAR_CODE: clear_code    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // engine state
  lcdwe_pkg::state_t state, state_next;
  logic [7:0]    tx_byte, tx_byte_next;     // byte being sent
  logic          rs, rs_next;
  logic [15:0]   hold, hold_next;           // wait on the low nibble
  logic [RW-1:0] remaining, remaining_next; // digits left (1 for plain bytes)
  logic          seen, seen_next;           // nonzero digit dropped above window
  logic [DW-1:0] digits, digits_next;

  // output register
  logic          out_valid, out_valid_next;
  logic          out_rs, out_rs_next;
  logic [3:0]    out_nib, out_nib_next;
  logic [15:0]   out_wait, out_wait_next;
  logic          out_last, out_last_next;

  logic          conv_start;
  logic          conv_done;
  logic [DW-1:0] conv_bcd;
  logic          out_free;
  logic [3:0]    top_digit;
  logic [7:0]    cursor_addr;

  lcdwe_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (req.number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  assign req.ready         = (state == lcdwe_pkg::ST_IDLE);
  assign strobe.valid      = out_valid;
  assign strobe.reg_select = out_rs;
  assign strobe.nibble     = out_nib;
  assign strobe.wait_us    = out_wait;
  assign strobe.last       = out_last;

  assign out_free  = !out_valid || strobe.ready;
  assign top_digit = digits[DW-1 -: 4];

  // DDRAM address: line 1 at 0x00, line 2 at 0x40, column counted from one
  assign cursor_addr = lcdwe_pkg::DDRAM_SET
                     + ((req.row == 2'd1) ? 8'h00 : lcdwe_pkg::LINE2_OFFSET)
                     + {3'b000, req.column} - 8'd1;

  always_comb begin
    state_next     = state;
    tx_byte_next   = tx_byte;
    rs_next        = rs;
    hold_next      = hold;
    remaining_next = remaining;
    seen_next      = seen;
    digits_next    = digits;
    out_valid_next = out_valid;
    out_rs_next    = out_rs;
    out_nib_next   = out_nib;
    out_wait_next  = out_wait;
    out_last_next  = out_last;
    conv_start     = 1'b0;

    if (out_valid && strobe.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      lcdwe_pkg::ST_IDLE: begin
        if (req.valid) begin
          remaining_next = RW'(1);
          hold_next      = byte_wait_us;
          unique case (req.kind)
            lcdwe_pkg::KIND_CMD: begin
              tx_byte_next = req.byte_value;
              rs_next      = 1'b0;
              state_next   = lcdwe_pkg::ST_HI;
            end
            lcdwe_pkg::KIND_CHAR: begin
              tx_byte_next = req.byte_value;
              rs_next      = 1'b1;
              state_next   = lcdwe_pkg::ST_HI;
            end
            lcdwe_pkg::KIND_CLEAR: begin
              tx_byte_next = clear_code;
              rs_next      = 1'b0;
              hold_next    = clear_wait_us;
              state_next   = lcdwe_pkg::ST_HI;
            end
            lcdwe_pkg::KIND_CURSOR: begin
              tx_byte_next = cursor_addr;
              rs_next      = 1'b0;
              state_next   = lcdwe_pkg::ST_HI;
            end
            lcdwe_pkg::KIND_NUMBER: begin
              conv_start = 1'b1;
              rs_next    = 1'b1;
              state_next = lcdwe_pkg::ST_CONV;
            end
            default: ;  // unused kinds: dropped without output
          endcase
        end
      end

      lcdwe_pkg::ST_CONV: begin
        if (conv_done) begin
          digits_next    = conv_bcd;
          remaining_next = RW'(lcdwe_pkg::NUM_DIGITS);
          seen_next      = 1'b0;
          state_next     = lcdwe_pkg::ST_SKIP;
        end
      end

      // Drop digits above the MAX_DIGITS window, then leading zeros unless a
      // nonzero digit was dropped above it. The last digit always stays.
      lcdwe_pkg::ST_SKIP: begin
        if ((remaining > RW'(MAX_DIGITS)) ||
            (!seen && (top_digit == 4'd0) && (remaining != RW'(1)))) begin
          seen_next      = seen | (top_digit != 4'd0);
          digits_next    = {digits[DW-5:0], 4'h0};
          remaining_next = remaining - 1'b1;
        end else begin
          tx_byte_next = {lcdwe_pkg::ASCII_DIGIT_HI, top_digit};
          state_next   = lcdwe_pkg::ST_HI;
        end
      end

      lcdwe_pkg::ST_HI: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_rs_next    = rs;
          out_nib_next   = tx_byte[7:4];
          out_wait_next  = 16'd0;
          out_last_next  = 1'b0;
          state_next     = lcdwe_pkg::ST_LO;
        end
      end

      lcdwe_pkg::ST_LO: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_rs_next    = rs;
          out_nib_next   = tx_byte[3:0];
          out_wait_next  = hold;
          out_last_next  = (remaining == RW'(1));
          if (remaining == RW'(1)) begin
            state_next = lcdwe_pkg::ST_IDLE;
          end else begin
            // next digit sits just below the current one
            tx_byte_next   = {lcdwe_pkg::ASCII_DIGIT_HI, digits[DW-5 -: 4]};
            digits_next    = {digits[DW-5:0], 4'h0};
            remaining_next = remaining - 1'b1;
            state_next     = lcdwe_pkg::ST_HI;
          end
        end
      end

      default: state_next = lcdwe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcdwe_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tx_byte   <= tx_byte_next;
    rs        <= rs_next;
    hold      <= hold_next;
    remaining <= remaining_next;
    seen      <= seen_next;
    digits    <= digits_next;
    out_rs    <= out_rs_next;
    out_nib   <= out_nib_next;
    out_wait  <= out_wait_next;
    out_last  <= out_last_next;
  end

endmodule

// ===== tb/sv/lcdwe_strobe_checker.sv =====
`timescale 1ns / 100ps
// Strobe checker for the character LCD 4-bit write engine: predicts nibble strobes.
// Depends on lcdwe_pkg and lcdwe_if.
module lcdwe_strobe_checker (
  input  logic        clk,
  input  logic        rst,
  lcdwe_req_if        req,
  lcdwe_strobe_if     strobe,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int         MAX_DIGITS = 20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        last;
  } strobe_t;

  logic [15:0] byte_wait;
  logic [15:0] clear_wait;
  logic [7:0]  clear_byte;
  strobe_t     expected_strobes[$];
  int          mismatches = 0;

  // one byte = high nibble (no wait), then low nibble (wait, last)
  task automatic push_byte(input logic rs, input logic [7:0] value,
                           input logic [15:0] hold, input logic final_byte);
    strobe_t s;
    s.reg_select = rs;
    s.nibble     = value[7:4];
    s.wait_us    = 16'd0;
    s.last       = 1'b0;
    expected_strobes.push_back(s);
    s.nibble  = value[3:0];
    s.wait_us = hold;
    s.last    = final_byte;
    expected_strobes.push_back(s);
  endtask

  task automatic expand_request(input logic [2:0] kind, input logic [7:0] bval,
                                input logic [1:0] row, input logic [4:0] col,
                                input logic [63:0] num);
    logic [7:0]  addr;
    logic [7:0]  digits [MAX_DIGITS];
    logic [63:0] rest;
    int          count;
    int          k;
    count = 0;
    rest  = num;
    case (kind)
      lcdwe_pkg::KIND_CMD:   push_byte(1'b0, bval, byte_wait, 1'b1);
      lcdwe_pkg::KIND_CHAR:  push_byte(1'b1, bval, byte_wait, 1'b1);
      lcdwe_pkg::KIND_CLEAR: push_byte(1'b0, clear_byte, clear_wait, 1'b1);
      lcdwe_pkg::KIND_CURSOR: begin
        // 8-bit sum; a column of zero or past 16 falls outside the line
        addr = lcdwe_pkg::DDRAM_SET
             + ((row == 2'd1) ? 8'h00 : lcdwe_pkg::LINE2_OFFSET)
             + {3'b000, col} - 8'd1;
        push_byte(1'b0, addr, byte_wait, 1'b1);
      end
      lcdwe_pkg::KIND_NUMBER: begin
        if (num == 64'd0) begin
          push_byte(1'b1, CHAR_ZERO, byte_wait, 1'b1);
        end else begin
          while (rest != 64'd0 && count < MAX_DIGITS) begin
            digits[count] = CHAR_ZERO + 8'(rest % 64'd10);
            rest = rest / 64'd10;
            count++;
          end
          for (k = count; k > 0; k--) begin
            push_byte(1'b1, digits[k-1], byte_wait, k == 1);
          end
        end
      end
      default: ;  // unused kinds produce nothing
    endcase
  endtask

  always @(posedge clk) begin : monitor
    strobe_t got;
    strobe_t want;
    if (rst) begin
      byte_wait  = lcdwe_pkg::BYTE_WAIT_RST;
      clear_wait = lcdwe_pkg::CLEAR_WAIT_RST;
      clear_byte = lcdwe_pkg::CLEAR_CODE_RST;
      expected_strobes.delete();
    end else begin
      // strobes first: a request taken on this edge cannot own them yet
      if (strobe.valid && strobe.ready) begin
        got.reg_select = strobe.reg_select;
        got.nibble     = strobe.nibble;
        got.wait_us    = strobe.wait_us;
        got.last       = strobe.last;
        if (expected_strobes.size() == 0) begin
          $display("%0t: unexpected strobe rs=%0d nibble=%h wait=%0d last=%0d",
                   $time, got.reg_select, got.nibble, got.wait_us, got.last);
          mismatches++;
        end else begin
          want = expected_strobes.pop_front();
          if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
              got.wait_us !== want.wait_us || got.last !== want.last) begin
            $display("%0t: strobe mismatch expected rs=%0d nibble=%h wait=%0d last=%0d",
                     $time, want.reg_select, want.nibble, want.wait_us, want.last);
            $display("%0t:                  actual rs=%0d nibble=%h wait=%0d last=%0d",
                     $time, got.reg_select, got.nibble, got.wait_us, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          lcdwe_pkg::CFG_BYTE_WAIT:  byte_wait  = cfg_data;
          lcdwe_pkg::CFG_CLEAR_WAIT: clear_wait = cfg_data;
          lcdwe_pkg::CFG_CLEAR_CODE: clear_byte = cfg_data[7:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        expand_request(req.kind, req.byte_value, req.row, req.column, req.number);
      end
    end
    errors  <= mismatches;
    pending <= expected_strobes.size();
  end

endmodule

// ===== tb/sv/tb_char_lcd_4bit_write_engine_core.sv =====
`timescale 1ns / 100ps
// Top of the LCD write engine testbench: clock, reset, requests, strobe stalls, verdict.
// Depends on lcdwe_pkg, lcdwe_if, the engine core and lcdwe_strobe_checker.
module tb_char_lcd_4bit_write_engine_core;

  // index past the register list; the engine must ignore writes to it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Slowest run: ~450 requests, 35% of the random ones numbers of up to 40
  // strobes, each strobe behind a sparse receiver.
  localparam int CYCLE_LIMIT      = 1_000_000;
  // a one-digit number needs BCD conversion inside the engine before its first strobe
  localparam int SETTLE_CYCLES    = 200;
  localparam int LONG_HOLD        = 400;
  localparam int RANDOM_PER_PHASE = 86;
  localparam int PHASES           = 5;

  // receiver stall patterns
  typedef enum int {
    SINK_OPEN,    // always ready
    SINK_COIN,    // ready half the time
    SINK_SPARSE,  // ready with probability 1/8
    SINK_MOSTLY   // ready with probability 3/4
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          cycle_count = 0;
  logic        hold_off_go = 1'b0;
  int          burst_left = 0;

  lcdwe_req_if    req();
  lcdwe_strobe_if strobe();

  char_lcd_4bit_write_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .strobe    (strobe),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcdwe_strobe_checker strobe_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .strobe    (strobe),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request and hold it until taken. Called at a clock edge; returns
  // after acceptance. Bursts of back-to-back requests are broken up
  // by random gaps (sometimes none, so some stretches run without idling).
  task automatic send_request(input logic [2:0] kind, input logic [7:0] bval,
                              input logic [1:0] row, input logic [4:0] col,
                              input logic [63:0] num);
    int gap;
    req.valid      <= 1'b1;
    req.kind       <= kind;
    req.byte_value <= bval;
    req.row        <= row;
    req.column     <= col;
    req.number     <= num;
    do @(posedge clk); while (!req.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Mostly well-formed requests; a quarter of the time each, the row and column
  // come from the full field, not the 1..2 / 1..16 window, and a few requests carry an unused kind.
  task automatic send_random_request(output bit useful);
    logic [2:0]  kind;
    logic [1:0]  row;
    logic [4:0]  col;
    logic [63:0] num;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       kind = lcdwe_pkg::KIND_NUMBER + 3'($urandom_range(1, 3));
    else if (pick < 20) kind = lcdwe_pkg::KIND_CMD;
    else if (pick < 40) kind = lcdwe_pkg::KIND_CHAR;
    else if (pick < 48) kind = lcdwe_pkg::KIND_CLEAR;
    else if (pick < 65) kind = lcdwe_pkg::KIND_CURSOR;
    else                kind = lcdwe_pkg::KIND_NUMBER;
    row = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
    col = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    // numbers of every digit count, plus small values and values near the top
    case ($urandom_range(0, 3))
      0:       num = {$urandom, $urandom};
      1:       num = {$urandom, $urandom} >> $urandom_range(0, 63);
      2:       num = 64'($urandom_range(0, 1000));
      default: num = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 9));
    endcase
    useful = (kind <= lcdwe_pkg::KIND_NUMBER);
    send_request(kind, 8'($urandom), row, col, num);
  endtask

  // Back-to-back register writes, then one write to the unused index.
  // The clear code's upper data byte is random and must be dropped.
  task automatic load_settings(input logic [15:0] bw, input logic [15:0] cw,
                               input logic [7:0] code);
    cfg_we    <= 1'b1;
    cfg_index <= lcdwe_pkg::CFG_BYTE_WAIT;
    cfg_data  <= bw;
    @(posedge clk);
    cfg_index <= lcdwe_pkg::CFG_CLEAR_WAIT;
    cfg_data  <= cw;
    @(posedge clk);
    cfg_index <= lcdwe_pkg::CFG_CLEAR_CODE;
    cfg_data  <= {8'($urandom), code};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering, wait for every predicted strobe, then let the engine settle
  // (an unused-kind request is dropped in the idle state and owes no strobe).
  // The first edge lets the checker count a request taken on the last edge.
  task automatic wait_idle();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall pattern in random spans, plus one long hold-off
  // once the stimulus asks for it, so the engine backs up into the request side.
  initial begin : strobe_sink
    sink_mode_t mode;
    int         span;
    bit         held;
    held = 1'b0;
    strobe.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_go && !held) begin
        held = 1'b1;
        strobe.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 64);
      repeat (span) begin
        case (mode)
          SINK_OPEN:   strobe.ready <= 1'b1;
          SINK_COIN:   strobe.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: strobe.ready <= ($urandom_range(0, 7) == 0);
          default:     strobe.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int sent;
    bit useful;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.kind       <= lcdwe_pkg::KIND_CMD;
    req.byte_value <= 8'h00;
    req.row        <= 2'd0;
    req.column     <= 5'd0;
    req.number     <= 64'd0;
    cfg_we         <= 1'b0;
    cfg_index      <= lcdwe_pkg::CFG_BYTE_WAIT;
    cfg_data       <= 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under reset register values.
    // byte extremes for command and character, a clear
    send_request(lcdwe_pkg::KIND_CMD, 8'h00, 2'd1, 5'd1, 64'd0);
    send_request(lcdwe_pkg::KIND_CMD, 8'hFF, 2'd2, 5'd16, '1);
    send_request(lcdwe_pkg::KIND_CHAR, 8'h00, 2'd3, 5'd31, 64'd5);
    send_request(lcdwe_pkg::KIND_CHAR, 8'hFF, 2'd0, 5'd0, 64'd0);
    send_request(lcdwe_pkg::KIND_CHAR, 8'h41, 2'd1, 5'd1, 64'd1);
    send_request(lcdwe_pkg::KIND_CLEAR, 8'hA5, 2'd1, 5'd1, 64'd7);
    // cursor corners, row codes 0 and 3 (second line), columns outside the line
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd1, 5'd1, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd1, 5'd16, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd2, 5'd1, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd2, 5'd16, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd0, 5'd7, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd3, 5'd31, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd1, 5'd0, 64'd0);
    send_request(lcdwe_pkg::KIND_CURSOR, 8'h00, 2'd2, 5'd0, 64'd0);
    // zero prints one '0'; digit-count boundaries; largest value is 20 digits
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd0);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd1);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd9);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd10);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd1234567890);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd9999999999999999999);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'd10000000000000000000);
    send_request(lcdwe_pkg::KIND_NUMBER, 8'h00, 2'd1, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    // unused kinds: no strobes, no side effects
    send_request(lcdwe_pkg::KIND_NUMBER + 3'd1, 8'h12, 2'd1, 5'd1, 64'd42);
    send_request(lcdwe_pkg::KIND_NUMBER + 3'd2, 8'h34, 2'd2, 5'd2, 64'd0);
    send_request(lcdwe_pkg::KIND_NUMBER + 3'd3, 8'h56, 2'd3, 5'd3, '1);

    // Random phases: reset values, all zeros, all ones, then random settings.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1:       load_settings(16'h0000, 16'h0000, 8'h00);
          2:       load_settings(16'hFFFF, 16'hFFFF, 8'hFF);
          default: load_settings(16'($urandom), 16'($urandom), 8'($urandom));
        endcase
      end
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        // long receiver hold-off early on, while requests keep coming
        if (phase == 0 && sent == 20) hold_off_go <= 1'b1;
        send_random_request(useful);
        if (useful) sent++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lcdwe_pkg.sv
src/lcdwe_if.sv
src/lcdwe_dabble.sv
src/char_lcd_4bit_write_engine_core.sv
tb/sv/lcdwe_strobe_checker.sv
tb/sv/tb_char_lcd_4bit_write_engine_core.sv
